>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> rtl/alpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alpd_pkg;

  localparam int HeaderDigitsDefault = 4;
  localparam int LenW = 14;
  localparam logic [LenW-1:0] LenMax = 14'd9999;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DEAD    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]      data;
    logic            is_header;
    logic            first;
    logic            last;
    logic [LenW-1:0] length;
    logic            err;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/alpd_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alpd_core #(
  parameter int HEADER_DIGITS = alpd_pkg::HeaderDigitsDefault
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    byte_in,
  output logic               res_valid,
  output alpd_pkg::res_t     res
);

  localparam int NdigInt = (HEADER_DIGITS < 1) ? 1 :
                           ((HEADER_DIGITS > 4) ? 4 : HEADER_DIGITS);
  localparam logic [2:0] Ndig = 3'(NdigInt);

  alpd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]                   pos_r, pos_nxt;
  logic [alpd_pkg::LenW-1:0]    acc_r, acc_nxt;
  logic                         ended_r, ended_nxt;
  logic [alpd_pkg::LenW-1:0]    rem_r, rem_nxt;

  logic                         is_digit;
  logic [alpd_pkg::LenW+2:0]    acc_x10;
  logic [alpd_pkg::LenW-1:0]    rem_dec;

  assign is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);
  // acc * 10 + digit; the low nibble of an ASCII digit is its value.
  assign acc_x10  = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0}
                  + {13'd0, byte_in[3:0]};
  assign rem_dec  = (rem_r != '0) ? (rem_r - 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= alpd_pkg::PH_IDLE;
      pos_r   <= '0;
      acc_r   <= '0;
      ended_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      ended_r <= ended_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    ended_nxt = ended_r;
    rem_nxt   = rem_r;
    res_valid = 1'b0;
    res       = '0;
    res.data  = byte_in;
    if (step) begin
      unique case (phase_r)
        alpd_pkg::PH_IDLE: begin
          // Zero bytes between messages are dropped silently.
          if (byte_in != 8'h00) begin
            res_valid     = 1'b1;
            res.is_header = 1'b1;
            res.first     = 1'b1;
            if (!is_digit) begin
              res.err   = 1'b1;
              phase_nxt = alpd_pkg::PH_DEAD;
            end else begin
              acc_nxt   = {10'd0, byte_in[3:0]};
              ended_nxt = 1'b0;
              pos_nxt   = 3'd1;
              phase_nxt = alpd_pkg::PH_HEADER;
            end
          end
        end
        alpd_pkg::PH_HEADER: begin
          res_valid     = 1'b1;
          res.is_header = 1'b1;
          if (pos_r < Ndig) begin
            if (!ended_r && is_digit) begin
              acc_nxt = (acc_x10 > (alpd_pkg::LenW+3)'(alpd_pkg::LenMax)) ?
                        alpd_pkg::LenMax : acc_x10[alpd_pkg::LenW-1:0];
            end else begin
              ended_nxt = 1'b1;
            end
            pos_nxt = pos_r + 3'd1;
          end else begin
            // Separator byte closes the header.
            pos_nxt = '0;
            if (acc_r == '0) begin
              res.last  = 1'b1;
              phase_nxt = alpd_pkg::PH_IDLE;
            end else begin
              rem_nxt   = acc_r;
              phase_nxt = alpd_pkg::PH_PAYLOAD;
            end
          end
        end
        alpd_pkg::PH_PAYLOAD: begin
          res_valid = 1'b1;
          rem_nxt   = rem_dec;
          if (rem_dec == '0) begin
            res.last   = 1'b1;
            res.length = acc_r;
            phase_nxt  = alpd_pkg::PH_IDLE;
          end
        end
        alpd_pkg::PH_DEAD: begin
          res_valid = 1'b0;
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_dead_silent, clk, rst_n, (phase_r == alpd_pkg::PH_DEAD) && res_valid)
  `ASSERT_ALWAYS(a_last_to_idle, clk, rst_n, (res_valid && res.last) |=> (phase_r == alpd_pkg::PH_IDLE))
  `ASSERT_ALWAYS(a_pos_range, clk, rst_n, (phase_r == alpd_pkg::PH_HEADER) |-> ((pos_r != 3'd0) && (pos_r <= Ndig)))
  `ASSERT_ALWAYS(a_err_first, clk, rst_n, (res_valid && res.err) |-> (res.first && !res.last))

endmodule

`default_nettype wire

>>> rtl/alpd_obuf.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alpd_obuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  alpd_pkg::res_t      push_data,
  output logic                push_ready,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output alpd_pkg::res_t      pop_data
);

  // Two entries let the core keep running while one result waits.
  alpd_pkg::res_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r == 2'd3)
  `ASSERT_NEVER(a_push_full, clk, rst_n, push && (cnt_r == 2'd2))
  `ASSERT_ALWAYS(a_ptr_track, clk, rst_n, (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))

endmodule

`default_nettype wire

>>> rtl/ascii_length_prefix_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Deframer for length-prefixed ASCII messages. It takes one byte per clock
// while the output buffer has room: each byte passes through an input
// register, one update of the framing state machine, and a two-entry output
// buffer, which presents its result. Every header, separator and payload
// byte comes out once, marked as header or payload and as first or last of
// its message; the last beat carries the parsed length (clamped to 9999).
// Zero bytes between messages are consumed with no result. A header that
// does not start with a digit yields one beat with out_header_error set,
// after which all input is consumed and dropped until reset. No setup time
// is needed after reset.
module ascii_length_prefix_deframer #(
  parameter int HEADER_DIGITS = alpd_pkg::HeaderDigitsDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_data_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_data_out,
  output logic                              out_is_header,
  output logic                              out_msg_first,
  output logic                              out_msg_last,
  output logic [alpd_pkg::LenW-1:0]         out_msg_length,
  output logic                              out_header_error
);

  logic           s_valid_r;
  logic [7:0]     s_data_r;
  logic           buf_ready;
  logic           step;
  logic           res_valid;
  alpd_pkg::res_t res;
  alpd_pkg::res_t head;

  assign step     = s_valid_r && buf_ready;
  assign in_ready = !s_valid_r || buf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_data_r <= in_data_in;
    end
  end

  alpd_core #(
    .HEADER_DIGITS(HEADER_DIGITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (s_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  alpd_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (buf_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (head)
  );

  assign out_data_out     = head.data;
  assign out_is_header    = head.is_header;
  assign out_msg_first    = head.first;
  assign out_msg_last     = head.last;
  assign out_msg_length   = head.length;
  assign out_header_error = head.err;

endmodule

`default_nettype wire
